@@ hw/rtl/ps2kd_pkg.sv @@
package ps2kd_pkg;

	localparam logic [7:0] CODE_EXT       = 8'hE0;
	localparam logic [7:0] CODE_BRK       = 8'hF0;
	localparam logic [7:0] CODE_LSHIFT    = 8'h12;
	localparam logic [7:0] CODE_RSHIFT    = 8'h59;
	localparam logic [7:0] CODE_CAPS      = 8'h58;
	localparam logic [7:0] CODE_UP        = 8'h75;
	localparam logic [7:0] CODE_DOWN      = 8'h72;
	localparam logic [7:0] CODE_LEFT      = 8'h6B;
	localparam logic [7:0] CODE_RIGHT     = 8'h74;

	localparam int unsigned SCAN_W = 8;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned KIND_W = 3;

	// prefix tracker, one-hot
	typedef enum logic [3:0] {
		PFX_IDLE    = 4'b0001,
		PFX_EXT     = 4'b0010,
		PFX_BRK     = 4'b0100,
		PFX_EXT_BRK = 4'b1000
	} prefix_t;

	typedef enum logic [KIND_W-1:0] {
		EV_NONE  = 3'd0,
		EV_CHAR  = 3'd1,
		EV_UP    = 3'd2,
		EV_DOWN  = 3'd3,
		EV_LEFT  = 3'd4,
		EV_RIGHT = 3'd5
	} event_kind_t;

	typedef struct packed {
		prefix_t prefix;
		logic    shift_held;
		logic    caps_on;
	} kb_state_t;

	// set-2 make code to lower-case ASCII; zero where no character
	function automatic logic [CHAR_W-1:0] key_lookup(input logic [SCAN_W-1:0] code);
		logic [CHAR_W-1:0] ch;
		begin
			case (code)
				8'd14:   ch = 7'h60; // `
				8'd21:   ch = 7'h71; // q
				8'd22:   ch = 7'h31; // 1
				8'd26:   ch = 7'h7A; // z
				8'd27:   ch = 7'h73; // s
				8'd28:   ch = 7'h61; // a
				8'd29:   ch = 7'h77; // w
				8'd30:   ch = 7'h32; // 2
				8'd33:   ch = 7'h63; // c
				8'd34:   ch = 7'h78; // x
				8'd35:   ch = 7'h64; // d
				8'd36:   ch = 7'h65; // e
				8'd37:   ch = 7'h34; // 4
				8'd38:   ch = 7'h33; // 3
				8'd41:   ch = 7'h20; // space
				8'd42:   ch = 7'h76; // v
				8'd43:   ch = 7'h66; // f
				8'd44:   ch = 7'h74; // t
				8'd45:   ch = 7'h72; // r
				8'd46:   ch = 7'h35; // 5
				8'd49:   ch = 7'h6E; // n
				8'd50:   ch = 7'h62; // b
				8'd51:   ch = 7'h68; // h
				8'd52:   ch = 7'h67; // g
				8'd53:   ch = 7'h79; // y
				8'd54:   ch = 7'h36; // 6
				8'd58:   ch = 7'h6D; // m
				8'd59:   ch = 7'h6A; // j
				8'd60:   ch = 7'h75; // u
				8'd61:   ch = 7'h37; // 7
				8'd62:   ch = 7'h38; // 8
				8'd65:   ch = 7'h2C; // ,
				8'd66:   ch = 7'h6B; // k
				8'd67:   ch = 7'h69; // i
				8'd68:   ch = 7'h6F; // o
				8'd69:   ch = 7'h30; // 0
				8'd70:   ch = 7'h39; // 9
				8'd73:   ch = 7'h2E; // .
				8'd74:   ch = 7'h2F; // /
				8'd75:   ch = 7'h6C; // l
				8'd76:   ch = 7'h3B; // ;
				8'd77:   ch = 7'h70; // p
				8'd78:   ch = 7'h2D; // -
				8'd82:   ch = 7'h27; // '
				8'd84:   ch = 7'h5B; // [
				8'd85:   ch = 7'h3D; // =
				8'd90:   ch = 7'h0D; // enter
				8'd91:   ch = 7'h5D; // ]
				8'd93:   ch = 7'h5C; // backslash
				8'd102:  ch = 7'h7F; // backspace
				8'd110:  ch = 7'h60; // `
				default: ch = '0;
			endcase
			return ch;
		end
	endfunction

endpackage

@@ hw/rtl/ps2kd_decode.sv @@
// Combinational decode of one scan byte against the current keyboard state.
module ps2kd_decode (
	input  logic [ps2kd_pkg::SCAN_W-1:0] scan_byte,
	input  ps2kd_pkg::kb_state_t         cur,
	output ps2kd_pkg::kb_state_t         nxt,
	output ps2kd_pkg::event_kind_t       kind,
	output logic [ps2kd_pkg::CHAR_W-1:0] char_code
);

	logic                         is_shift;
	logic                         do_key;
	logic [ps2kd_pkg::CHAR_W-1:0] raw_ch;
	logic                         is_lower;
	logic [ps2kd_pkg::CHAR_W-1:0] ch;

	assign is_shift = (scan_byte == ps2kd_pkg::CODE_LSHIFT) ||
	                  (scan_byte == ps2kd_pkg::CODE_RSHIFT);

	// prefix / modifier tracking
	always_comb begin
		nxt    = cur;
		do_key = 1'b0;
		nxt.prefix = ps2kd_pkg::PFX_IDLE;
		case (cur.prefix)
			ps2kd_pkg::PFX_EXT: begin
				if (scan_byte == ps2kd_pkg::CODE_BRK)
					nxt.prefix = ps2kd_pkg::PFX_EXT_BRK;
				else
					do_key = 1'b1;
			end
			ps2kd_pkg::PFX_BRK: begin
				if (is_shift)
					nxt.shift_held = 1'b0;
			end
			ps2kd_pkg::PFX_EXT_BRK: begin
				// extended break: byte dropped
			end
			default: begin
				if (scan_byte == ps2kd_pkg::CODE_EXT)
					nxt.prefix = ps2kd_pkg::PFX_EXT;
				else if (scan_byte == ps2kd_pkg::CODE_BRK)
					nxt.prefix = ps2kd_pkg::PFX_BRK;
				else if (is_shift)
					nxt.shift_held = 1'b1;
				else if (scan_byte == ps2kd_pkg::CODE_CAPS)
					nxt.caps_on = ~cur.caps_on;
				else
					do_key = 1'b1;
			end
		endcase
	end

	// key lookup; codes past the table fall into the lookup default
	assign raw_ch   = ps2kd_pkg::key_lookup(scan_byte);
	assign is_lower = (raw_ch >= 7'h61) && (raw_ch <= 7'h7A);
	assign ch       = (is_lower && (cur.caps_on ^ cur.shift_held)) ?
	                  (raw_ch & 7'h5F) : raw_ch;

	always_comb begin
		kind      = ps2kd_pkg::EV_NONE;
		char_code = '0;
		if (do_key) begin
			case (scan_byte)
				ps2kd_pkg::CODE_UP:    kind = ps2kd_pkg::EV_UP;
				ps2kd_pkg::CODE_DOWN:  kind = ps2kd_pkg::EV_DOWN;
				ps2kd_pkg::CODE_LEFT:  kind = ps2kd_pkg::EV_LEFT;
				ps2kd_pkg::CODE_RIGHT: kind = ps2kd_pkg::EV_RIGHT;
				default: begin
					if (ch != '0) begin
						kind      = ps2kd_pkg::EV_CHAR;
						char_code = ch;
					end
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/ps2_scancode_key_decoder.sv @@
// PS/2 scan-code set 2 key decoder.
// Slave stream (s_*): one raw keyboard byte per transaction in s_tdata.
// Master stream (m_*): exactly one result per input byte. m_tuser carries the
//   event kind (none, char, up, down, left, right); m_tdata carries the ASCII
//   code for a char event and zero otherwise. Prefix, modifier and break bytes
//   still produce a result, with kind none.
// Pipeline: input register (_s1), then the decode logic, then the output
//   register. A byte accepted into stage 1 moves on into the output register
//   when that register is empty or being read, and then shows on m_tvalid.
// Throughput: one byte per cycle unless the master side stalls; the only loop
//   is the prefix/shift/caps state, updated as the byte leaves stage 1.
// Reset (arst_n low, asynchronous): prefix tracker idle, shift and caps off,
//   both stages empty.
// Stall: when m_tready is low the output register holds its transaction,
//   stage 1 holds its byte, and s_tready drops once stage 1 is full. No byte
//   is lost or repeated.
module ps2_scancode_key_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] scan_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
	output logic [2:0] m_tuser    // [2:0] event_kind
);

	logic [ps2kd_pkg::SCAN_W-1:0] byte_s1;
	logic                         valid_s1;
	ps2kd_pkg::kb_state_t         state_q;
	ps2kd_pkg::kb_state_t         state_nxt;
	ps2kd_pkg::event_kind_t       kind_nxt;
	logic [ps2kd_pkg::CHAR_W-1:0] char_nxt;
	ps2kd_pkg::event_kind_t       kind_q;
	logic [ps2kd_pkg::CHAR_W-1:0] char_q;
	logic                         out_valid_q;
	logic                         advance;

	// stage 1 moves into the output register when that register is empty or being read
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	ps2kd_decode u_decode (
		.scan_byte (byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.kind      (kind_nxt),
		.char_code (char_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.prefix     <= ps2kd_pkg::PFX_IDLE;
			state_q.shift_held <= 1'b0;
			state_q.caps_on    <= 1'b0;
			out_valid_q        <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_nxt;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= kind_nxt;
			char_q <= char_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tuser  = kind_q;

endmodule

@@ tb/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no transaction on either side before the run is called hung
	localparam int QUIET_LIMIT = 2000;
	// cycles the receiver holds m_tready low in the back-pressure test
	localparam int HOLD_CYCLES = 300;
	// extra cycles of drain after the last expected result, to catch strays
	localparam int DRAIN_CYCLES = 8;

	// set-2 make code -> lower-case ASCII, zero where the key gives no character
	localparam logic [0:111][6:0] KEYMAP = {
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h60, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h71, 7'h31, 7'h00,
		7'h00, 7'h00, 7'h7A, 7'h73, 7'h61, 7'h77, 7'h32, 7'h00,
		7'h00, 7'h63, 7'h78, 7'h64, 7'h65, 7'h34, 7'h33, 7'h00,
		7'h00, 7'h20, 7'h76, 7'h66, 7'h74, 7'h72, 7'h35, 7'h00,
		7'h00, 7'h6E, 7'h62, 7'h68, 7'h67, 7'h79, 7'h36, 7'h00,
		7'h00, 7'h00, 7'h6D, 7'h6A, 7'h75, 7'h37, 7'h38, 7'h00,
		7'h00, 7'h2C, 7'h6B, 7'h69, 7'h6F, 7'h30, 7'h39, 7'h00,
		7'h00, 7'h2E, 7'h2F, 7'h6C, 7'h3B, 7'h70, 7'h2D, 7'h00,
		7'h00, 7'h00, 7'h27, 7'h00, 7'h5B, 7'h3D, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h0D, 7'h5D, 7'h00, 7'h5C, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h7F, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h60, 7'h00
	};

	typedef struct packed {
		ps2kd_pkg::event_kind_t       kind;
		logic [ps2kd_pkg::CHAR_W-1:0] ch;
	} key_event_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = 8'h00;   // [7:0] scan_byte
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;            // [6:0] char_code, [7] zero
	logic [2:0]        m_tuser;            // [2:0] event_kind

	// keyboard state as the decoder should see it
	ps2kd_pkg::prefix_t kb_prefix = ps2kd_pkg::PFX_IDLE;
	logic              kb_shift  = 1'b0;
	logic              kb_caps   = 1'b0;

	key_event_t        expected_keys [$];
	int                errors       = 0;
	int                quiet_cycles = 0;
	int                idle_pct     = 0;   // sender: chance per cycle of no offer
	int                stall_pct    = 0;   // receiver: chance per cycle of tready low
	int                hold_left    = 0;   // forced receiver hold-off, in cycles
	int                bytes_sent   = 0;

	ps2_scancode_key_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// key decode proper: cursor codes first, then the table, then case folding
	function automatic key_event_t lookup_key(input logic [7:0] code);
		key_event_t r;
		logic [6:0] c;
		r.kind = ps2kd_pkg::EV_NONE;
		r.ch   = '0;
		if (code == ps2kd_pkg::CODE_UP) begin
			r.kind = ps2kd_pkg::EV_UP;
		end else if (code == ps2kd_pkg::CODE_DOWN) begin
			r.kind = ps2kd_pkg::EV_DOWN;
		end else if (code == ps2kd_pkg::CODE_LEFT) begin
			r.kind = ps2kd_pkg::EV_LEFT;
		end else if (code == ps2kd_pkg::CODE_RIGHT) begin
			r.kind = ps2kd_pkg::EV_RIGHT;
		end else if (code < 8'd112) begin
			c = KEYMAP[code];
			// letters only; digits and punctuation ignore shift here
			if (c >= 7'h61 && c <= 7'h7A && (kb_caps ^ kb_shift))
				c = c - 7'd32;
			if (c != '0) begin
				r.kind = ps2kd_pkg::EV_CHAR;
				r.ch   = c;
			end
		end
		return r;
	endfunction

	// advance the keyboard state by one byte and return the event it yields
	function automatic key_event_t decode_scan_byte(input logic [7:0] b);
		key_event_t r;
		r.kind = ps2kd_pkg::EV_NONE;
		r.ch   = '0;
		case (kb_prefix)
			ps2kd_pkg::PFX_EXT: begin
				// after E0 everything but F0 is a key, modifiers included
				if (b == ps2kd_pkg::CODE_BRK) begin
					kb_prefix = ps2kd_pkg::PFX_EXT_BRK;
				end else begin
					kb_prefix = ps2kd_pkg::PFX_IDLE;
					r = lookup_key(b);
				end
			end
			ps2kd_pkg::PFX_BRK: begin
				// break code is swallowed; only a shift release matters
				if (b == ps2kd_pkg::CODE_LSHIFT || b == ps2kd_pkg::CODE_RSHIFT)
					kb_shift = 1'b0;
				kb_prefix = ps2kd_pkg::PFX_IDLE;
			end
			ps2kd_pkg::PFX_EXT_BRK: begin
				kb_prefix = ps2kd_pkg::PFX_IDLE;
			end
			default: begin
				kb_prefix = ps2kd_pkg::PFX_IDLE;
				if (b == ps2kd_pkg::CODE_EXT)
					kb_prefix = ps2kd_pkg::PFX_EXT;
				else if (b == ps2kd_pkg::CODE_BRK)
					kb_prefix = ps2kd_pkg::PFX_BRK;
				else if (b == ps2kd_pkg::CODE_LSHIFT || b == ps2kd_pkg::CODE_RSHIFT)
					kb_shift = 1'b1;
				else if (b == ps2kd_pkg::CODE_CAPS)
					kb_caps = ~kb_caps;
				else
					r = lookup_key(b);
			end
		endcase
		return r;
	endfunction

	// Offer one byte; random idle cycles go in front of it. tvalid is only
	// lowered inside the idle loop, so it is never dropped and raised in one step.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		// accepted at this edge
		expected_keys.push_back(decode_scan_byte(b));
		bytes_sent++;
	endtask

	// Receiver: random stalls, or a forced hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker: every output transaction against the oldest expectation.
	always @(posedge clk) begin
		key_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_keys.size() == 0) begin
				$error("result with nothing pending: event_kind %0d char_code 0x%02h",
					m_tuser, m_tdata);
				errors++;
			end else begin
				want = expected_keys.pop_front();
				if (m_tuser !== want.kind) begin
					$error("event_kind: expected %0d, got %0d", want.kind, m_tuser);
					errors++;
				end
				if (m_tdata !== {1'b0, want.ch}) begin
					$error("char_code: expected 0x%02h, got 0x%02h", {1'b0, want.ch}, m_tdata);
					errors++;
				end
			end
		end
	end

	// Watchdog: too long with no transaction on either side means a hang.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One random key-stroke sequence: mostly well-formed make/break/extended
	// traffic, the rest modifiers and raw noise bytes.
	task automatic send_random_stroke();
		int pick;
		logic [7:0] key;
		pick = $urandom_range(99);
		// up and left get a fair share; otherwise any code in table range
		// plus the 16 codes past its end
		case ($urandom_range(5))
			0:       key = ps2kd_pkg::CODE_UP;
			1:       key = ps2kd_pkg::CODE_LEFT;
			default: key = 8'($urandom_range(127));
		endcase
		if (pick < 40) begin
			send_byte(key);
		end else if (pick < 55) begin
			// key release; sometimes a shift release
			send_byte(ps2kd_pkg::CODE_BRK);
			send_byte(($urandom_range(3) == 0) ? ps2kd_pkg::CODE_RSHIFT : key);
		end else if (pick < 65) begin
			send_byte(ps2kd_pkg::CODE_EXT);
			send_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : key);
		end else if (pick < 73) begin
			send_byte(ps2kd_pkg::CODE_EXT);
			send_byte(ps2kd_pkg::CODE_BRK);
			send_byte(8'($urandom_range(255)));
		end else if (pick < 83) begin
			send_byte($urandom_range(1) ? ps2kd_pkg::CODE_LSHIFT : ps2kd_pkg::CODE_RSHIFT);
		end else if (pick < 88) begin
			send_byte(ps2kd_pkg::CODE_CAPS);
		end else begin
			send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic run_random(input int n_bytes, input int idle, input int stall);
		int start;
		idle_pct  = idle;
		stall_pct = stall;
		start     = bytes_sent;
		while (bytes_sent - start < n_bytes)
			send_random_stroke();
	endtask

	// Extremes, every event kind but right, modifier handling and the prefix corner cases.
	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		send_byte(8'h00);                   // lowest code, blank table entry
		send_byte(8'hFF);                   // highest code, past the table
		send_byte(8'h70);                   // first code past the table
		send_byte(8'h6E);                   // last table entry with a character
		send_byte(8'h1C);                   // 'a'
		send_byte(ps2kd_pkg::CODE_LSHIFT);  // shift down
		send_byte(8'h1C);                   // 'A'
		send_byte(8'h16);                   // '1' stays a digit under shift
		send_byte(ps2kd_pkg::CODE_CAPS);    // caps on with shift held: lower case
		send_byte(8'h1C);
		send_byte(ps2kd_pkg::CODE_BRK);     // shift up
		send_byte(ps2kd_pkg::CODE_LSHIFT);
		send_byte(8'h1C);                   // caps alone: upper case
		send_byte(ps2kd_pkg::CODE_CAPS);    // caps off
		send_byte(ps2kd_pkg::CODE_UP);      // cursor without E0
		send_byte(ps2kd_pkg::CODE_EXT);     // cursor with E0
		send_byte(ps2kd_pkg::CODE_DOWN);
		send_byte(ps2kd_pkg::CODE_LEFT);
		send_byte(ps2kd_pkg::CODE_EXT);     // extended break swallows the key
		send_byte(ps2kd_pkg::CODE_BRK);
		send_byte(ps2kd_pkg::CODE_RIGHT);
		send_byte(ps2kd_pkg::CODE_EXT);     // E0 E0: second one decoded as a plain key
		send_byte(ps2kd_pkg::CODE_EXT);
		send_byte(ps2kd_pkg::CODE_EXT);     // E0 then shift: no flag change
		send_byte(ps2kd_pkg::CODE_RSHIFT);
		send_byte(8'h5A);                   // enter
		send_byte(8'h66);                   // backspace
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Random traffic across the idle/stall mixes.
	task automatic test_random_traffic();
		run_random(170, 0, 0);
		run_random(165, 85, 0);
		run_random(165, 0, 85);
		run_random(165, 15, 15);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the pipeline fills and s_tready has to drop.
	task automatic test_backpressure();
		idle_pct  = 0;
		stall_pct = 0;
		hold_left = HOLD_CYCLES;
		run_random(50, 0, 0);
		s_tvalid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic();
		test_backpressure();

		// drain with the receiver always ready, then watch for strays
		stall_pct = 0;
		while (expected_keys.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
